@@ src/sbb_pkg.sv @@
// Shared widths, constants and the item record for the Ball-Berry conductance block.
package sbb_pkg;

    localparam int unsigned A_W    = 17;
    localparam int unsigned CA_W   = 16;
    localparam int unsigned RH_W   = 16;
    localparam int unsigned REG_W  = 16;
    localparam int unsigned G_W    = 20;
    localparam int unsigned N_W    = G_W + 1;
    localparam int unsigned P_W    = 50;
    localparam int unsigned Q_W    = 28;
    localparam int unsigned KM_W   = 25;
    localparam int unsigned B125_W = 23;
    localparam int unsigned CS_W   = 25;
    localparam int unsigned IDX_W  = 1;

    localparam logic [IDX_W-1:0] REG_INTERCEPT = 1'b0;
    localparam logic [IDX_W-1:0] REG_SLOPE     = 1'b1;

    localparam logic [REG_W-1:0] INTERCEPT_RST = 16'd5243;
    localparam logic [REG_W-1:0] SLOPE_RST     = 16'd2496;

    localparam logic [G_W-1:0] G_MAX   = '1;
    localparam logic [G_W-1:0] G_FLOOR = 20'd160;

    // Search record handed from cell to cell.
    typedef struct packed {
        logic [N_W-1:0]    n;
        logic [P_W-1:0]    pp;
        logic [Q_W-1:0]    q;
        logic [KM_W-1:0]   k;
        logic [KM_W-1:0]   m;
        logic [B125_W-1:0] b125;
        logic              sat_force;
        logic              fix_floor;
    } t_item;

endpackage

@@ src/sbb_in_if.sv @@
// Input channel: assimilation, ambient CO2 and relative humidity.
interface sbb_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [sbb_pkg::A_W-1:0]     assimilation;
    logic        [sbb_pkg::CA_W-1:0]    ambient_co2;
    logic        [sbb_pkg::RH_W-1:0]    rel_humidity;

    modport source (output valid, output assimilation, output ambient_co2,
                    output rel_humidity, input ready);
    modport sink   (input valid, input assimilation, input ambient_co2,
                    input rel_humidity, output ready);
endinterface

@@ src/sbb_out_if.sv @@
// Output channel: conductance and saturation flag.
interface sbb_out_if;
    logic                         valid;
    logic                         ready;
    logic [sbb_pkg::G_W-1:0]      conductance;
    logic                         saturated;

    modport source (output valid, output conductance, output saturated, input ready);
    modport sink   (input valid, input conductance, input saturated, output ready);
endinterface

@@ src/sbb_front.sv @@
// Front end: forms the CO2 ratio terms and the per-item search constants.
module sbb_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_v,
    input  logic signed [sbb_pkg::A_W-1:0]    i_a,
    input  logic [sbb_pkg::CA_W-1:0]          i_ca,
    input  logic [sbb_pkg::RH_W-1:0]          i_rh,
    input  logic [sbb_pkg::REG_W-1:0]         i_intercept,
    input  logic [sbb_pkg::REG_W-1:0]         i_slope,
    output logic                              o_v,
    output sbb_pkg::t_item                    o_item
);
    localparam int unsigned SP_W = sbb_pkg::REG_W + 19;

    logic signed [sbb_pkg::CS_W-1:0] cs;
    logic signed [sbb_pkg::CS_W-1:0] a_e;
    logic [18:0]                     p0;
    logic [sbb_pkg::Q_W-1:0]         q0;
    logic [38:0]                     p_mega;
    logic                            satf0;
    logic                            fix0;

    logic                        r1_v, r2_v, r3_v;
    logic [18:0]                 r1_p;
    logic [sbb_pkg::Q_W-1:0]     r1_q, r2_q;
    logic [sbb_pkg::RH_W-1:0]    r1_rh;
    logic                        r1_satf, r1_fix, r2_satf, r2_fix;
    logic [SP_W-1:0]             r2_sp;
    logic [sbb_pkg::KM_W-1:0]    r2_k, r2_m;
    logic [sbb_pkg::B125_W-1:0]  r2_b125;
    sbb_pkg::t_item              r3_item;

    always_comb begin
        a_e    = sbb_pkg::CS_W'(i_a);
        cs     = $signed({9'b0, i_ca} * 25'd96) - a_e * 25'sd7;
        satf0  = 1'b0;
        p0     = '0;
        q0     = 28'd1;
        if (a_e < 0) begin
            p0 = '0;
            q0 = 28'd1;
        end else begin
            if (cs < 0) begin
                // Negative surface CO2 is taken as one mole per mole.
                p0 = 19'(i_a[15:0]);
                q0 = 28'd256000000;
            end else if (cs == 0) begin
                satf0 = (a_e != 0);
                p0    = '0;
                q0    = 28'd1;
            end else begin
                p0 = 19'(i_a[15:0]) * 19'd6;
                q0 = sbb_pkg::Q_W'(cs);
            end
        end
        p_mega = 39'(p0) * 39'd1000000;
        if (!(a_e < 0) && (p_mega < 39'(q0))) begin
            p0 = 19'd1;
            q0 = 28'd1000000;
        end
        fix0 = (i_intercept == '0) && !satf0 && ((a_e < 0) || (i_rh == '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
        if (i_en) begin
            r1_p    <= p0;
            r1_q    <= q0;
            r1_rh   <= i_rh;
            r1_satf <= satf0;
            r1_fix  <= fix0;

            r2_sp   <= SP_W'(i_slope) * SP_W'(r1_p);
            r2_q    <= r1_q;
            r2_k    <= sbb_pkg::KM_W'(i_intercept) * 25'd125 + 25'd9830400;
            r2_m    <= sbb_pkg::KM_W'(r1_rh) * 25'd150
                       + sbb_pkg::KM_W'(i_intercept) * 25'd125;
            r2_b125 <= sbb_pkg::B125_W'(i_intercept) * 23'd125;
            r2_satf <= r1_satf;
            r2_fix  <= r1_fix;

            r3_item.n         <= '0;
            r3_item.pp        <= sbb_pkg::P_W'(r2_sp) * 50'd32000;
            r3_item.q         <= r2_q;
            r3_item.k         <= r2_k;
            r3_item.m         <= r2_m;
            r3_item.b125      <= r2_b125;
            r3_item.sat_force <= r2_satf;
            r3_item.fix_floor <= r2_fix;
        end
    end

    assign o_v    = r3_v;
    assign o_item = r3_item;
endmodule

@@ src/sbb_cell.sv @@
// One search cell: decides one bit of the conductance over four stages.
module sbb_cell #(
    parameter int unsigned BIT = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_v,
    input  sbb_pkg::t_item i_item,
    output logic           o_v,
    output sbb_pkg::t_item o_item
);
    logic [sbb_pkg::N_W-1:0] cand;
    logic signed [30:0]      t;

    logic           r1_v, r2_v, r3_v, r4_v;
    sbb_pkg::t_item r1_item, r2_item, r3_item, r4_item;
    sbb_pkg::t_item n_item;
    logic [sbb_pkg::N_W-1:0] r1_cand, r2_cand, r3_cand;
    logic           r1_pos, r2_pos, r3_pos;
    logic [29:0]    r1_tu;
    logic [30:0]    r1_s1, r1_s2;
    logic [60:0]    r2_x;
    logic [55:0]    r2_pr_lo, r2_pr_hi;
    logic [58:0]    r3_l_lo;
    logic [57:0]    r3_l_hi;
    logic [80:0]    r3_rhs;
    logic [88:0]    lhs;
    logic           le;

    always_comb begin
        cand = i_item.n | (sbb_pkg::N_W'(1) << BIT);
        t    = $signed({1'b0, cand, 9'b0}) - $signed({8'b0, i_item.b125});
        lhs  = 89'(r3_l_lo) + {r3_l_hi, 31'b0};
        // A candidate at or below the intercept always passes.
        le   = !r3_pos || (lhs <= 89'(r3_rhs));
        n_item   = r3_item;
        n_item.n = le ? r3_cand : r3_item.n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
        if (i_en) begin
            r1_item  <= i_item;
            r1_cand  <= cand;
            r1_pos   <= !t[30] && (t != 0);
            r1_tu    <= t[29:0];
            r1_s1    <= 31'(t[29:0]) + 31'(i_item.k);
            r1_s2    <= 31'(t[29:0]) + 31'(i_item.m);

            r2_item  <= r1_item;
            r2_cand  <= r1_cand;
            r2_pos   <= r1_pos;
            r2_x     <= 61'(r1_tu) * 61'(r1_s1);
            r2_pr_lo <= 56'(r1_item.pp[24:0]) * 56'(r1_s2);
            r2_pr_hi <= 56'(r1_item.pp[49:25]) * 56'(r1_s2);

            r3_item  <= r2_item;
            r3_cand  <= r2_cand;
            r3_pos   <= r2_pos;
            r3_l_lo  <= 59'(r2_x[30:0]) * 59'(r2_item.q);
            r3_l_hi  <= 58'(r2_x[60:31]) * 58'(r2_item.q);
            r3_rhs   <= 81'(r2_pr_lo) + {r2_pr_hi, 25'b0};

            r4_item  <= n_item;
        end
    end

    assign o_v    = r4_v;
    assign o_item = r4_item;
endmodule

@@ src/sbb_outbuf.sv @@
// Output register with a skid entry; maps the search result to the output fields.
module sbb_outbuf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_v,
    input  sbb_pkg::t_item i_item,
    output logic           o_en,
    sbb_out_if.source      o_out
);
    logic [sbb_pkg::G_W-1:0] g;
    logic                    sat;
    logic                    r_out_v, r_skid_v;
    logic [sbb_pkg::G_W-1:0] r_out_g, r_skid_g;
    logic                    r_out_s, r_skid_s;

    always_comb begin
        if (i_item.fix_floor) begin
            g   = sbb_pkg::G_FLOOR;
            sat = 1'b0;
        end else if (i_item.sat_force || i_item.n[sbb_pkg::G_W]) begin
            g   = sbb_pkg::G_MAX;
            sat = 1'b1;
        end else begin
            g   = i_item.n[sbb_pkg::G_W-1:0];
            sat = 1'b0;
        end
    end

    assign o_en = !r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_out.ready) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || o_out.ready) begin
            r_out_v <= i_v;
        end else if (i_v) begin
            r_skid_v <= 1'b1;
        end
        if (r_skid_v) begin
            if (o_out.ready) begin
                r_out_g <= r_skid_g;
                r_out_s <= r_skid_s;
            end
        end else if (!r_out_v || o_out.ready) begin
            r_out_g <= g;
            r_out_s <= sat;
        end else begin
            r_skid_g <= g;
            r_skid_s <= sat;
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.conductance = r_out_g;
    assign o_out.saturated   = r_out_s;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v) else $error("skid entry held without output entry");
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_v |=> !r_skid_v) else $error("skid filled while output was empty");
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_s) |-> (r_out_g == sbb_pkg::G_MAX))
        else $error("saturated result not at full scale");
endmodule

@@ src/stomatal_conductance_ball_berry.sv @@
// Top level of the Ball-Berry stomatal conductance block.
//
// Items enter on i_in (assimilation, ambient CO2, relative humidity) and one
// result per item leaves on o_out (conductance in 1/16 mmol/m2/s, saturated).
// The intercept (index 0) and slope (index 1) registers are written through
// i_cfg_we/i_cfg_idx/i_cfg_data; the user must write them only while no item
// is in flight, which the block itself does not enforce. A slope of zero is
// stored as one LSB. The pipeline is three front-end stages, 21 search cells
// of four stages each and the output register. One item is taken every cycle
// unless the pipeline stalls; each cell decides one bit of the result and the
// cells form a fixed pipeline, so every item passes through every cell once.
// Reset restores the register defaults and empties the pipeline. When the
// receiver stalls, the output register holds its item and a skid entry takes
// the next one; after that the whole pipeline and i_in.ready hold until the
// receiver takes an item.
module stomatal_conductance_ball_berry (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sbb_in_if.sink                         i_in,
    sbb_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [sbb_pkg::IDX_W-1:0]      i_cfg_idx,
    input  logic [sbb_pkg::REG_W-1:0]      i_cfg_data
);
    localparam int unsigned NCELL = sbb_pkg::N_W;

    logic [sbb_pkg::REG_W-1:0] r_intercept, r_slope;
    logic                      en;
    logic                      v_chain [NCELL+1];
    sbb_pkg::t_item            item_chain [NCELL+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_intercept <= sbb_pkg::INTERCEPT_RST;
            r_slope     <= sbb_pkg::SLOPE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sbb_pkg::REG_INTERCEPT: r_intercept <= i_cfg_data;
                sbb_pkg::REG_SLOPE: begin
                    r_slope <= (i_cfg_data == '0) ? sbb_pkg::REG_W'(1) : i_cfg_data;
                end
                default: ;
            endcase
        end
    end

    assign i_in.ready = en;

    sbb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_v         (i_in.valid),
        .i_a         (i_in.assimilation),
        .i_ca        (i_in.ambient_co2),
        .i_rh        (i_in.rel_humidity),
        .i_intercept (r_intercept),
        .i_slope     (r_slope),
        .o_v         (v_chain[0]),
        .o_item      (item_chain[0])
    );

    // Cells run from the top bit of the search range down to bit zero.
    for (genvar gi = 0; gi < NCELL; gi++) begin : g_cell
        sbb_cell #(.BIT(NCELL - 1 - gi)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_v     (v_chain[gi]),
            .i_item  (item_chain[gi]),
            .o_v     (v_chain[gi+1]),
            .o_item  (item_chain[gi+1])
        );
    end

    sbb_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v     (v_chain[NCELL]),
        .i_item  (item_chain[NCELL]),
        .o_en    (en),
        .o_out   (o_out)
    );

    a_slope_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slope != '0) else $error("slope register holds zero");
    a_stall_holds_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(v_chain[0])) else $error("front stage moved while stalled");
    a_stall_holds_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(v_chain[NCELL])) else $error("last cell moved while stalled");
endmodule

@@ test/tb.sv @@
// Self-checking testbench for the Ball-Berry stomatal conductance block.
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic signed [sbb_pkg::A_W-1:0] assim;
        logic [sbb_pkg::CA_W-1:0]       co2;
        logic [sbb_pkg::RH_W-1:0]       rh;
    } t_leaf;

    typedef struct {
        logic [sbb_pkg::G_W-1:0] cond;
        logic                    sat;
    } t_gsw;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [sbb_pkg::IDX_W-1:0] i_cfg_idx = sbb_pkg::REG_INTERCEPT;
    logic [sbb_pkg::REG_W-1:0] i_cfg_data = '0;

    sbb_in_if  in_if ();
    sbb_out_if out_if ();

    stomatal_conductance_ball_berry dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if.sink),
        .o_out      (out_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    t_leaf leaf_q[$];
    t_gsw  gsw_q[$];
    longint beta0 = longint'(sbb_pkg::INTERCEPT_RST);
    longint beta1 = longint'(sbb_pkg::SLOPE_RST);
    int errors = 0;
    int n_checked = 0;
    int n_saturated = 0;

    // True when n/16000 mol does not exceed the conductance for ratio p/q.
    function automatic bit gsw_at_least(longint n, longint p, longint q, longint rh);
        longint t, k, m;
        logic [127:0] lhs, rhs;
        t = 512 * n - 125 * beta0;
        if (t <= 0) return 1'b1;
        k = 125 * beta0 + 9830400;
        m = 150 * rh + 125 * beta0;
        lhs = 128'(q) * 128'(t) * 128'(t + k);
        rhs = 128'(32000 * beta1 * p) * 128'(t + m);
        return lhs <= rhs;
    endfunction

    function automatic t_gsw conductance_of(t_leaf lf);
        t_gsw r;
        longint a, cs, p, q, lo, hi, mid, rh;
        a = longint'(lf.assim);
        rh = longint'(lf.rh);
        r.sat = 1'b0;
        r.cond = '0;
        if (a < 0) begin
            p = 0; q = 1;
        end else begin
            cs = 96 * longint'(lf.co2) - 7 * a;
            if (cs < 0) begin
                p = a; q = 256000000;
            end else if (cs == 0) begin
                if (a > 0) begin
                    r.cond = sbb_pkg::G_MAX; r.sat = 1'b1;
                    return r;
                end
                p = 0; q = 1;
            end else begin
                p = 6 * a; q = cs;
            end
            // Ratio floor of 1e-6.
            if (p * 1000000 < q) begin
                p = 1; q = 1000000;
            end
        end
        if (beta0 == 0 && (p == 0 || rh == 0)) begin
            r.cond = sbb_pkg::G_FLOOR;
            return r;
        end
        if (gsw_at_least(64'd1 << sbb_pkg::G_W, p, q, rh)) begin
            r.cond = sbb_pkg::G_MAX; r.sat = 1'b1;
            return r;
        end
        lo = 0;
        hi = longint'(sbb_pkg::G_MAX);
        for (int i = 0; i < 21 && lo < hi; i++) begin
            mid = (lo + hi + 1) >> 1;
            if (gsw_at_least(mid, p, q, rh)) lo = mid;
            else hi = mid - 1;
        end
        r.cond = lo[sbb_pkg::G_W-1:0];
        return r;
    endfunction

    // Sender: bursts of items separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!(in_if.valid && !in_if.ready)) begin
            if (in_if.valid && in_if.ready) begin
                gsw_q.push_back(conductance_of(leaf_q[0]));
                void'(leaf_q.pop_front());
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_if.valid <= 1'b0;
            end else if (leaf_q.size() > 0) begin
                in_if.valid <= 1'b1;
                in_if.assimilation <= leaf_q[0].assim;
                in_if.ambient_co2 <= leaf_q[0].co2;
                in_if.rel_humidity <= leaf_q[0].rh;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 7);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: drives ready from a stall mode that is picked again at random.
    int cyc = 0;
    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc % 64 == 0) stall_mode <= $urandom_range(0, 2);
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (gsw_q.size() == 0) begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("Unexpected result: cond=%0d sat=%0b",
                                 out_if.conductance, out_if.saturated);
                end else begin
                    n_checked <= n_checked + 1;
                    if (gsw_q[0].sat) n_saturated <= n_saturated + 1;
                    if (out_if.conductance !== gsw_q[0].cond
                            || out_if.saturated !== gsw_q[0].sat) begin
                        errors <= errors + 1;
                        if (errors < 10)
                            $display({"Result mismatch: expected cond=%0d sat=%0b,",
                                      " got cond=%0d sat=%0b"},
                                     gsw_q[0].cond, gsw_q[0].sat,
                                     out_if.conductance, out_if.saturated);
                    end
                    void'(gsw_q.pop_front());
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_if.ready <= 1'b0;
            end else if (stall_mode == 1) begin
                out_if.ready <= ($urandom_range(0, 9) >= 3);
            end else if (stall_mode == 2 && $urandom_range(0, 15) == 0) begin
                stall_left <= $urandom_range(1, 20);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic add_leaf(int a, int ca, int rh);
        t_leaf lf;
        lf.assim = a[sbb_pkg::A_W-1:0];
        lf.co2 = ca[sbb_pkg::CA_W-1:0];
        lf.rh = rh[sbb_pkg::RH_W-1:0];
        leaf_q.push_back(lf);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while ((leaf_q.size() > 0 || in_if.valid || gsw_q.size() > 0) && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        if (guard >= 200000) begin
            $display("Stalled with %0d results outstanding", gsw_q.size());
            errors += gsw_q.size() + 1;
            gsw_q.delete();
        end
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [sbb_pkg::IDX_W-1:0] idx, logic [sbb_pkg::REG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == sbb_pkg::REG_INTERCEPT) beta0 = longint'(val);
        else beta1 = (val == 0) ? 1 : longint'(val);
    endtask

    task automatic random_leaves(int count);
        int a, ca, rh, k, sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 19);
            ca = $urandom_range(0, 65535);
            rh = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1)) ? 0 : 65535)
                                              : $urandom_range(0, 65535);
            if (sel < 3) begin
                a = -int'($urandom_range(1, 65536));
            end else if (sel == 3) begin
                // Surface CO2 exactly zero.
                k = $urandom_range(0, 682);
                a = 96 * k;
                ca = 7 * k;
            end else if (sel < 6) begin
                a = $urandom_range(0, 65535);
            end else if (sel < 8) begin
                a = $urandom_range(0, 8);
            end else begin
                a = $urandom_range(0, 6000);
                ca = $urandom_range(4000, 12000);
            end
            add_leaf(a, ca, rh);
        end
    endtask

    task automatic directed_leaves();
        add_leaf(-65536, 6000, 40000);
        add_leaf(-1, 0, 65535);
        add_leaf(65535, 0, 65535);
        add_leaf(65535, 65535, 0);
        add_leaf(0, 0, 30000);
        add_leaf(0, 65535, 0);
        add_leaf(96, 7, 20000);
        add_leaf(1, 65535, 65535);
        add_leaf(2560, 6400, 45875);
        add_leaf(5000, 4000, 52000);
        add_leaf(21845, 43690, 43690);
        add_leaf(43690, 21845, 21845);
    endtask

    task automatic run_phase(int count);
        directed_leaves();
        random_leaves(count);
        wait_drained();
    endtask

    initial begin
        in_if.valid = 1'b0;
        in_if.assimilation = '0;
        in_if.ambient_co2 = '0;
        in_if.rel_humidity = '0;
        out_if.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_phase(250);
        write_reg(sbb_pkg::REG_INTERCEPT, 16'd0);
        write_reg(sbb_pkg::REG_SLOPE, 16'd1);
        run_phase(200);
        write_reg(sbb_pkg::REG_INTERCEPT, 16'hFFFF);
        write_reg(sbb_pkg::REG_SLOPE, 16'hFFFF);
        run_phase(200);
        write_reg(sbb_pkg::REG_INTERCEPT, 16'd0);
        write_reg(sbb_pkg::REG_SLOPE, 16'd0);
        run_phase(200);
        write_reg(sbb_pkg::REG_INTERCEPT, 16'($urandom_range(0, 65535)));
        write_reg(sbb_pkg::REG_SLOPE, 16'($urandom_range(1, 65535)));
        run_phase(150);
        write_reg(sbb_pkg::REG_INTERCEPT, 16'($urandom_range(0, 20000)));
        write_reg(sbb_pkg::REG_SLOPE, 16'($urandom_range(256, 4096)));
        run_phase(150);
        $display("Checked %0d results over six register settings, %0d of them saturated.",
                 n_checked, n_saturated);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
